// ===== hw/rtl/zfeq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Zero-forcing equalizer and hard QAM demapper package
// Shared payload types, modulation codes and slicer scale factors.
// ============================================================================
package zfeq_pkg;

    localparam int SAMPLE_WIDTH = 16;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t rx_real;
        sample_t rx_imag;
        sample_t chan_real;
        sample_t chan_imag;
    } in_item_t;

    typedef struct packed {
        logic [5:0] hard_bits;
        logic [2:0] bit_count;
        logic       zero_channel;
    } out_item_t;

    typedef enum logic [1:0] {
        MOD_QPSK  = 2'd0,
        MOD_QAM16 = 2'd1,
        MOD_QAM64 = 2'd2
    } mod_t;

    localparam logic [2:0] COUNT_QPSK  = 3'd2;
    localparam logic [2:0] COUNT_QAM16 = 3'd4;
    localparam logic [2:0] COUNT_QAM64 = 3'd6;

    // Threshold tests k*N^2 against m*P^2, where the threshold squared is m/k.
    localparam int QAM16_N_SCALE     = 5;
    localparam int QAM16_P_SCALE     = 2;
    localparam int QAM64_OUT_N_SCALE = 21;
    localparam int QAM64_OUT_P_SCALE = 8;
    localparam int QAM64_TOP_N_SCALE = 7;
    localparam int QAM64_TOP_P_SCALE = 6;
    localparam int QAM64_IN_P_SCALE  = 2;

    typedef struct packed {
        logic ni_neg;
        logic nq_neg;
        logic ni_pos;
        logic nq_pos;
        logic p_zero;
    } flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/zf_equalize_hard_qam_demap_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Zero-forcing equalizer with hard QAM demapper
// Equalizes one subcarrier per item and slices it into hard bits.
// ============================================================================
// Each input item carries a received subcarrier value and its channel
// estimate. The block forms N = Y * conj(H) and P = |H|^2 and slices N / P
// into Gray-coded hard bits without any division, by exact comparisons of
// scaled squares. The modulation register selects QPSK, 16-QAM or 64-QAM;
// it is written through cfg_we and cfg_data, by the user only while no
// item is in flight, which the block itself does not enforce. Both channels
// use valid and stall; an item moves on a rising edge where valid is high
// and stall is low. The datapath is a six-stage pipeline: products, sums,
// magnitudes, squares, scaled squares and the slicer with its output
// register. One item can be accepted in every cycle unless the receiver
// stalls with every stage full. When the receiver stalls, the output item
// holds and the earlier stages keep filling their empty slots; the input
// is stalled only once every stage holds an item. Reset clears all stage
// valid bits and sets the modulation to QPSK.
// ============================================================================
module zf_equalize_hard_qam_demap_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire zfeq_pkg::in_item_t in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output zfeq_pkg::out_item_t  out_data,
    input  wire                  cfg_we,
    input  wire  [1:0]           cfg_data
);
    import zfeq_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int MW = 2 * W;
    localparam int QW = 4 * W;
    localparam int CW = 4 * W + 5;
    localparam int NS = 6;

    logic [1:0]    modulation_reg;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg <= MOD_QPSK;
        end
        else if (cfg_we)
        begin
            modulation_reg <= cfg_data;
        end
    end

    always_comb
    begin
        ready[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        if (ready[0])
        begin
            valid_next[0] = in_valid;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
        end
        for (int i = 1; i < NS; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NS-1];

    // Stage 1: products.
    sample_t yr, yi, hr, hi;
    logic signed [PW-1:0] hr_yr_next, hi_yi_next, hr_yi_next, hi_yr_next;
    logic signed [PW-1:0] hr_hr_next, hi_hi_next;
    logic signed [PW-1:0] hr_yr_reg, hi_yi_reg, hr_yi_reg, hi_yr_reg;
    logic signed [PW-1:0] hr_hr_reg, hi_hi_reg;

    assign yr = in_data.rx_real;
    assign yi = in_data.rx_imag;
    assign hr = in_data.chan_real;
    assign hi = in_data.chan_imag;

    always_comb
    begin
        hr_yr_next = hr * yr;
        hi_yi_next = hi * yi;
        hr_yi_next = hr * yi;
        hi_yr_next = hi * yr;
        hr_hr_next = hr * hr;
        hi_hi_next = hi * hi;
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            hr_yr_reg <= hr_yr_next;
            hi_yi_reg <= hi_yi_next;
            hr_yi_reg <= hr_yi_next;
            hi_yr_reg <= hi_yr_next;
            hr_hr_reg <= hr_hr_next;
            hi_hi_reg <= hi_hi_next;
        end
    end

    // Stage 2: numerator and channel power.
    logic signed [SW-1:0] ni_sum_next, nq_sum_next, ni_sum_reg, nq_sum_reg;
    logic [MW-1:0]        p_next, p2_reg;

    always_comb
    begin
        ni_sum_next = SW'(hr_yr_reg) + SW'(hi_yi_reg);
        nq_sum_next = SW'(hr_yi_reg) - SW'(hi_yr_reg);
        p_next      = MW'(hr_hr_reg) + MW'(hi_hi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            ni_sum_reg <= ni_sum_next;
            nq_sum_reg <= nq_sum_next;
            p2_reg     <= p_next;
        end
    end

    // Stage 3: magnitudes and sign flags.
    logic [MW-1:0] ni_mag_next, nq_mag_next, ni_mag_reg, nq_mag_reg, p3_reg;
    flags_t        flags3_next, flags3_reg, flags4_reg, flags5_reg;

    always_comb
    begin
        ni_mag_next        = MW'(ni_sum_reg[SW-1] ? -ni_sum_reg : ni_sum_reg);
        nq_mag_next        = MW'(nq_sum_reg[SW-1] ? -nq_sum_reg : nq_sum_reg);
        flags3_next.ni_neg = ni_sum_reg[SW-1];
        flags3_next.nq_neg = nq_sum_reg[SW-1];
        flags3_next.ni_pos = !ni_sum_reg[SW-1] && (ni_sum_reg != '0);
        flags3_next.nq_pos = !nq_sum_reg[SW-1] && (nq_sum_reg != '0);
        flags3_next.p_zero = (p2_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            ni_mag_reg <= ni_mag_next;
            nq_mag_reg <= nq_mag_next;
            p3_reg     <= p2_reg;
            flags3_reg <= flags3_next;
        end
    end

    // Stage 4: squares.
    logic [QW-1:0] ni_sq_next, nq_sq_next, p_sq_next;
    logic [QW-1:0] ni_sq_reg, nq_sq_reg, p_sq_reg;

    always_comb
    begin
        ni_sq_next = ni_mag_reg * ni_mag_reg;
        nq_sq_next = nq_mag_reg * nq_mag_reg;
        p_sq_next  = p3_reg * p3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            ni_sq_reg  <= ni_sq_next;
            nq_sq_reg  <= nq_sq_next;
            p_sq_reg   <= p_sq_next;
            flags4_reg <= flags3_reg;
        end
    end

    // Stage 5: scaled squares.
    logic [CW-1:0] ni5_next, ni21_next, ni7_next, nq5_next, nq21_next, nq7_next;
    logic [CW-1:0] p2_next, p8_next, p6_next;
    logic [CW-1:0] ni5_reg, ni21_reg, ni7_reg, nq5_reg, nq21_reg, nq7_reg;
    logic [CW-1:0] pk2_reg, pk8_reg, pk6_reg;

    always_comb
    begin
        ni5_next  = CW'(ni_sq_reg) * CW'(QAM16_N_SCALE);
        ni21_next = CW'(ni_sq_reg) * CW'(QAM64_OUT_N_SCALE);
        ni7_next  = CW'(ni_sq_reg) * CW'(QAM64_TOP_N_SCALE);
        nq5_next  = CW'(nq_sq_reg) * CW'(QAM16_N_SCALE);
        nq21_next = CW'(nq_sq_reg) * CW'(QAM64_OUT_N_SCALE);
        nq7_next  = CW'(nq_sq_reg) * CW'(QAM64_TOP_N_SCALE);
        p2_next   = CW'(p_sq_reg) * CW'(QAM16_P_SCALE);
        p8_next   = CW'(p_sq_reg) * CW'(QAM64_OUT_P_SCALE);
        p6_next   = CW'(p_sq_reg) * CW'(QAM64_TOP_P_SCALE);
    end

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            ni5_reg    <= ni5_next;
            ni21_reg   <= ni21_next;
            ni7_reg    <= ni7_next;
            nq5_reg    <= nq5_next;
            nq21_reg   <= nq21_next;
            nq7_reg    <= nq7_next;
            pk2_reg    <= p2_next;
            pk8_reg    <= p8_next;
            pk6_reg    <= p6_next;
            flags5_reg <= flags4_reg;
        end
    end

    // Stage 6: slicer and output register. The 64-QAM inner test shares the
    // 16-QAM power scale, both being two.
    logic      i_in16, q_in16, i_out64, q_out64, i_top64, q_top64, i_mid64, q_mid64;
    out_item_t out_next, out_reg;

    always_comb
    begin
        i_in16  = ni5_reg <= pk2_reg;
        q_in16  = nq5_reg <= pk2_reg;
        i_out64 = ni21_reg > pk8_reg;
        q_out64 = nq21_reg > pk8_reg;
        i_top64 = ni7_reg <= pk6_reg;
        q_top64 = nq7_reg <= pk6_reg;
        i_mid64 = ni21_reg > CW'(QAM64_IN_P_SCALE / QAM16_P_SCALE) * pk2_reg;
        q_mid64 = nq21_reg > CW'(QAM64_IN_P_SCALE / QAM16_P_SCALE) * pk2_reg;
        out_next.zero_channel = flags5_reg.p_zero;
        case (mod_t'(modulation_reg))
            MOD_QAM16:
            begin
                out_next.bit_count = COUNT_QAM16;
                out_next.hard_bits = {2'b00, q_in16, !flags5_reg.nq_neg,
                                      i_in16, !flags5_reg.ni_neg};
            end
            MOD_QAM64:
            begin
                out_next.bit_count = COUNT_QAM64;
                out_next.hard_bits = {q_out64 ? q_top64 : q_mid64, !q_out64,
                                      flags5_reg.nq_pos,
                                      i_out64 ? i_top64 : i_mid64, !i_out64,
                                      flags5_reg.ni_pos};
            end
            default:
            begin
                out_next.bit_count = COUNT_QPSK;
                out_next.hard_bits = {4'b0000, !flags5_reg.nq_neg, !flags5_reg.ni_neg};
            end
        endcase
        if (flags5_reg.p_zero)
        begin
            out_next.hard_bits = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[5])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled while a pipeline stage is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_channel |-> (out_data.hard_bits == '0))
        else $error("bits set on a zero-power channel");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.bit_count == COUNT_QPSK)
                   || (out_data.bit_count == COUNT_QAM16)
                   || (out_data.bit_count == COUNT_QAM64))
        else $error("bad bit count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.bit_count == COUNT_QPSK) |-> (out_data.hard_bits[5:2] == '0))
        else $error("QPSK item has bits above its count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.bit_count == COUNT_QAM16) |-> (out_data.hard_bits[5:4] == '0))
        else $error("16-QAM item has bits above its count");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Zero-forcing equalizer and hard QAM demapper testbench
// Streams subcarriers through the core under every modulation setting,
// with random gaps on the input and random stalls on the output. An
// exact integer model predicts every hard decision, and a scoreboard
// compares each result item field by field, in order.
// ============================================================================
module testbench;

    import zfeq_pkg::*;

    localparam logic [1:0] MOD_UNUSED  = 2'd3;
    localparam int         ITEMS_PER_PHASE = 60;
    localparam int         CYCLE_LIMIT = 200000;

    class demap_checker;
        logic [1:0]  mode;
        out_item_t   pending_decisions[$];
        int unsigned failures;

        function automatic logic [2:0] slice_branch(longint n, longint pw, logic [1:0] m);
            logic [79:0] nm;
            logic [79:0] pm;
            logic [79:0] nsq;
            logic [79:0] psq;
            logic [2:0]  b;
            nm  = (n < 0) ? -n : n;
            pm  = pw;
            nsq = nm * nm;
            psq = pm * pm;
            b   = '0;
            // Each threshold test compares k*N^2 with m*P^2 for threshold^2 = m/k.
            case (m)
                MOD_QAM16:
                begin
                    b[0] = (n >= 0);
                    b[1] = (5 * nsq <= 2 * psq);
                end
                MOD_QAM64:
                begin
                    b[0] = (n > 0);
                    if (21 * nsq > 8 * psq)
                    begin
                        b[2] = (7 * nsq <= 6 * psq);
                    end
                    else
                    begin
                        b[1] = 1'b1;
                        b[2] = (21 * nsq > 2 * psq);
                    end
                end
                default:
                begin
                    b[0] = (n >= 0);
                end
            endcase
            return b;
        endfunction

        function automatic out_item_t predict_decision(in_item_t s);
            longint     yr;
            longint     yi;
            longint     hr;
            longint     hi;
            longint     ni;
            longint     nq;
            longint     pw;
            logic [1:0] eff;
            int         half;
            out_item_t  r;
            yr  = s.rx_real;
            yi  = s.rx_imag;
            hr  = s.chan_real;
            hi  = s.chan_imag;
            ni  = hr * yr + hi * yi;
            nq  = hr * yi - hi * yr;
            pw  = hr * hr + hi * hi;
            eff = (mode == MOD_UNUSED) ? MOD_QPSK : mode;
            case (eff)
                MOD_QAM16:
                begin
                    half        = 2;
                    r.bit_count = COUNT_QAM16;
                end
                MOD_QAM64:
                begin
                    half        = 3;
                    r.bit_count = COUNT_QAM64;
                end
                default:
                begin
                    half        = 1;
                    r.bit_count = COUNT_QPSK;
                end
            endcase
            r.zero_channel = (pw == 0);
            r.hard_bits    = '0;
            if (pw != 0)
            begin
                r.hard_bits = 6'(slice_branch(ni, pw, eff))
                            | (6'(slice_branch(nq, pw, eff)) << half);
            end
            return r;
        endfunction

        function void note_subcarrier(in_item_t s);
            pending_decisions.push_back(predict_decision(s));
        endfunction

        function void check_decision(out_item_t got);
            out_item_t want;
            if (pending_decisions.size() == 0)
            begin
                $error("unexpected result item %h", got);
                failures++;
                return;
            end
            want = pending_decisions.pop_front();
            if (got.hard_bits !== want.hard_bits)
            begin
                $error("hard_bits: expected %h, got %h", want.hard_bits, got.hard_bits);
                failures++;
            end
            if (got.bit_count !== want.bit_count)
            begin
                $error("bit_count: expected %0d, got %0d", want.bit_count, got.bit_count);
                failures++;
            end
            if (got.zero_channel !== want.zero_channel)
            begin
                $error("zero_channel: expected %b, got %b",
                       want.zero_channel, got.zero_channel);
                failures++;
            end
        endfunction

        function int pending();
            return pending_decisions.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_data;

    demap_checker board = new();
    bit          tx_calm;
    bit          rx_calm;
    int unsigned cycles = 0;

    logic [1:0]  phase_mode[8] = '{MOD_QPSK, MOD_QAM16, MOD_QAM64, MOD_UNUSED,
                                   MOD_QAM64, MOD_QAM16, MOD_QPSK, MOD_QAM64};

    zf_equalize_hard_qam_demap_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic in_item_t subcarrier(int yr, int yi, int hr, int hi);
        in_item_t s;
        s.rx_real   = sample_t'(yr);
        s.rx_imag   = sample_t'(yi);
        s.chan_real = sample_t'(hr);
        s.chan_imag = sample_t'(hi);
        return s;
    endfunction

    function automatic in_item_t random_subcarrier();
        int kind;
        kind = $urandom_range(0, 15);
        if (kind == 0)
        begin
            return subcarrier($urandom, $urandom, 0, 0);
        end
        else if (kind <= 5)
        begin
            return subcarrier($urandom, $urandom, $urandom, $urandom);
        end
        else if (kind <= 11)
        begin
            return subcarrier(int'($urandom_range(0, 24000)) - 12000,
                              int'($urandom_range(0, 24000)) - 12000,
                              int'($urandom_range(0, 32767)) - 16384,
                              int'($urandom_range(0, 32767)) - 16384);
        end
        return subcarrier(int'($urandom_range(0, 15)) - 8, int'($urandom_range(0, 15)) - 8,
                          int'($urandom_range(0, 15)) - 8, int'($urandom_range(0, 15)) - 8);
    endfunction

    task automatic send_subcarrier(in_item_t s);
        int gap;
        in_data  <= s;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_subcarrier(s);
        @(negedge clk);
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_modulation(logic [1:0] m);
        cfg_data   <= m;
        cfg_we     <= 1'b1;
        board.mode = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        in_item_t cases[12];
        cases[0]  = subcarrier(0, 0, 0, 0);
        cases[1]  = subcarrier(32767, -32768, 0, 0);
        cases[2]  = subcarrier(-32768, -32768, -32768, -32768);
        cases[3]  = subcarrier(32767, 32767, 32767, 32767);
        cases[4]  = subcarrier(-32768, 32767, 32767, -32768);
        cases[5]  = subcarrier(0, 0, 8192, 0);
        cases[6]  = subcarrier(5181, -5182, 8192, 0);
        cases[7]  = subcarrier(2528, -2529, 8192, 0);
        cases[8]  = subcarrier(5056, -5057, 8192, 0);
        cases[9]  = subcarrier(7584, -7585, 8192, 0);
        cases[10] = subcarrier(7585, -2529, 0, 8192);
        cases[11] = subcarrier(1, -1, -32768, -32768);
        foreach (cases[i])
        begin
            send_subcarrier(cases[i]);
        end
        wait_drained();
    endtask

    task automatic run_random(int count, bit hold_midway);
        for (int i = 0; i < count; i++)
        begin
            if (hold_midway && i == count / 2)
            begin
                wait_drained();
            end
            send_subcarrier(random_subcarrier());
        end
        wait_drained();
    endtask

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            int hold;
            hold = rx_calm ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            board.check_decision(out_data);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_data = MOD_QPSK;
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        board.mode = MOD_QPSK;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_random(ITEMS_PER_PHASE, 1'b0);
        write_modulation(MOD_QAM64);
        run_directed();
        write_modulation(MOD_QAM16);
        run_directed();

        for (int ph = 1; ph < 8; ph++)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            write_modulation(phase_mode[ph]);
            run_random(ITEMS_PER_PHASE, ph == 2);
        end

        repeat (20) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d result items never arrived", board.pending());
            board.failures++;
        end
        if (board.failures == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
